// ===== hdl/acte_pkg.sv =====
// ----------------------------------------------------------------------------
// acte_pkg
// shared types, constants and helpers for the access code table
// ----------------------------------------------------------------------------
package acte_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int CODE_BYTES    = 4;

  localparam int CODE_BITS = (CODE_BYTES * 8 >= 32) ? 32 : CODE_BYTES * 8;
  localparam logic [31:0] CODE_MASK =
    (CODE_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << CODE_BITS) - 64'd1);

  localparam logic [31:0] MIN_PER_DAY  = 32'd1440;
  localparam logic [31:0] NO_ALARM     = 32'hFFFF_FFFF;
  localparam logic [31:0] MAX_DEADLINE = 32'hFFFF_FFFE;

  typedef enum logic [2:0] {
    OP_MATCH  = 3'd0,
    OP_ADD    = 3'd1,
    OP_INVAL  = 3'd2,
    OP_EXPIRE = 3'd3,
    OP_CLEAR  = 3'd4
  } op_t;

  localparam logic [2:0] EXP_NEVER  = 3'd0;
  localparam logic [2:0] EXP_MINUTE = 3'd1;
  localparam logic [2:0] EXP_DAY    = 3'd2;
  localparam logic [2:0] EXP_3DAYS  = 3'd3;
  localparam logic [2:0] EXP_WEEK   = 3'd4;
  localparam logic [2:0] EXP_30DAYS = 3'd5;

  // request token handed from cell to cell
  typedef struct packed {
    logic        live;
    op_t         op;
    logic [31:0] code;
    logic        expires;
    logic [31:0] deadline;
    logic [31:0] now;
    logic        done;
    logic        ok;
    logic [31:0] alarm;
  } acte_tok_t;

  function automatic logic [31:0] duration_of(input logic [2:0] choice);
    logic [31:0] d;
    unique case (choice)
      EXP_MINUTE: d = 32'd1;
      EXP_DAY:    d = MIN_PER_DAY;
      EXP_3DAYS:  d = 32'd3 * MIN_PER_DAY;
      EXP_WEEK:   d = 32'd7 * MIN_PER_DAY;
      EXP_30DAYS: d = 32'd30 * MIN_PER_DAY;
      default:    d = 32'd0;
    endcase
    return d;
  endfunction

endpackage

// ===== hdl/acte_in_if.sv =====
// ----------------------------------------------------------------------------
// acte_in_if
// request channel of the access code table
// ----------------------------------------------------------------------------
interface acte_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [31:0] code_value;
  logic [2:0]  expiry_choice;
  logic [31:0] now_minutes;

  modport source (output valid, op, code_value, expiry_choice, now_minutes, input ready);
  modport sink   (input valid, op, code_value, expiry_choice, now_minutes, output ready);
endinterface

// ===== hdl/acte_out_if.sv =====
// ----------------------------------------------------------------------------
// acte_out_if
// result channel of the access code table
// ----------------------------------------------------------------------------
interface acte_out_if;
  logic        valid;
  logic        ready;
  logic        success;
  logic [31:0] next_alarm;

  modport source (output valid, success, next_alarm, input ready);
  modport sink   (input valid, success, next_alarm, output ready);
endinterface

// ===== hdl/acte_cell.sv =====
// ----------------------------------------------------------------------------
// acte_cell
// one table slot; applies the passing request and forwards it one cell on
// ----------------------------------------------------------------------------
module acte_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                last,
  input  acte_pkg::acte_tok_t tok_in,
  output acte_pkg::acte_tok_t tok_out
);
  import acte_pkg::*;

  logic        valid;
  logic        expires;
  logic [31:0] code;
  logic [31:0] deadline;

  logic        valid_next;
  logic        expires_next;
  logic [31:0] code_next;
  logic [31:0] deadline_next;
  logic        hit;
  acte_tok_t   tok_next;

  always_comb begin
    valid_next    = valid;
    expires_next  = expires;
    code_next     = code;
    deadline_next = deadline;
    tok_next      = tok_in;
    hit           = valid && (code == tok_in.code);
    unique case (tok_in.op)
      OP_MATCH: begin
        tok_next.ok = tok_in.ok | hit;
      end
      OP_ADD: begin
        // first free slot, or the last one when the table is full
        if (!tok_in.done && (!valid || last)) begin
          valid_next    = 1'b1;
          code_next     = tok_in.code;
          expires_next  = tok_in.expires;
          deadline_next = tok_in.deadline;
          tok_next.done = 1'b1;
          tok_next.ok   = !valid;
        end
      end
      OP_INVAL: begin
        if (!tok_in.done && hit) begin
          valid_next    = 1'b0;
          tok_next.done = 1'b1;
          tok_next.ok   = 1'b1;
        end
      end
      OP_EXPIRE: begin
        if (valid && expires && (deadline < tok_in.now)) begin
          valid_next = 1'b0;
        end
        tok_next.ok = 1'b1;
      end
      OP_CLEAR: begin
        valid_next   = 1'b0;
        expires_next = 1'b0;
        code_next    = '0;
        tok_next.ok  = 1'b1;
      end
      default: begin
        tok_next.ok = 1'b0;
      end
    endcase
    if (valid_next && expires_next && (deadline_next < tok_in.alarm)) begin
      tok_next.alarm = deadline_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= 1'b0;
      expires <= 1'b0;
      code    <= '0;
    end else if (tok_in.live) begin
      valid   <= valid_next;
      expires <= expires_next;
      code    <= code_next;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_in.live) begin
      deadline <= deadline_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.live <= 1'b0;
    end else begin
      tok_out.live <= tok_in.live;
    end
    tok_out.op       <= tok_next.op;
    tok_out.code     <= tok_next.code;
    tok_out.expires  <= tok_next.expires;
    tok_out.deadline <= tok_next.deadline;
    tok_out.now      <= tok_next.now;
    tok_out.done     <= tok_next.done;
    tok_out.ok       <= tok_next.ok;
    tok_out.alarm    <= tok_next.alarm;
  end

`ifndef NO_ASSERTIONS
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    tok_in.live && tok_in.op == OP_CLEAR |=> !valid && !expires)
    else $error("slot still valid after clear");
  a_add_done: assert property (@(posedge clk) disable iff (rst)
    tok_in.live && tok_in.op == OP_ADD && last |=> tok_out.done)
    else $error("add left the table without a slot");
  a_alarm_mono: assert property (@(posedge clk) disable iff (rst)
    tok_in.live |=> tok_out.alarm <= $past(tok_in.alarm))
    else $error("alarm grew across a cell");
`endif
endmodule

// ===== hdl/access_code_table_with_expiry_top.sv =====
// ----------------------------------------------------------------------------
// access_code_table_with_expiry_top
// access code table with per-entry expiry, built as a row of slot cells
// ----------------------------------------------------------------------------
// usage:
//   in_ch carries one request: op (match, add, invalidate, expire, clear),
//   code_value, expiry_choice and now_minutes. out_ch returns one result per
//   request: success and next_alarm, the earliest deadline still armed.
//   a request is registered, then walks the row of TABLE_ENTRIES cells, one
//   cell per cycle; each cell updates its slot and folds its deadline into
//   the running minimum; the last cell's token is registered onto out_ch.
//   one request is in flight at a time: in_ch.ready stays low from accept
//   until the result is taken, so a new request waits for the walk along
//   the row and for out_ch. a stalled out_ch holds the result and keeps
//   in_ch closed. reset empties every slot at once and clears both
//   channels; in_ch.ready stays low while rst is high.
// ----------------------------------------------------------------------------
module access_code_table_with_expiry_top (
  input logic       clk,
  input logic       rst,
  acte_in_if.sink   in_ch,
  acte_out_if.source out_ch
);
  import acte_pkg::*;

  acte_tok_t             chain [TABLE_ENTRIES+1];
  logic [TABLE_ENTRIES:0] live_vec;
  logic                  busy;
  logic                  in_fire;
  logic                  out_fire;
  logic [32:0]           sum;

  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_fire    = out_ch.valid && out_ch.ready;
  assign in_ch.ready = !busy && !rst;
  assign sum = {1'b0, in_ch.now_minutes} + {1'b0, duration_of(in_ch.expiry_choice)};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (in_fire) begin
      busy <= 1'b1;
    end else if (out_fire) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0].live <= 1'b0;
    end else begin
      chain[0].live <= in_fire;
    end
    if (in_fire) begin
      chain[0].op       <= op_t'(in_ch.op);
      chain[0].code     <= in_ch.code_value & CODE_MASK;
      chain[0].expires  <= duration_of(in_ch.expiry_choice) != 32'd0;
      chain[0].deadline <= (sum > {1'b0, MAX_DEADLINE}) ? MAX_DEADLINE : sum[31:0];
      chain[0].now      <= in_ch.now_minutes;
      chain[0].done     <= 1'b0;
      chain[0].ok       <= 1'b0;
      chain[0].alarm    <= NO_ALARM;
    end
  end

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    acte_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .last    (i == TABLE_ENTRIES - 1),
      .tok_in  (chain[i]),
      .tok_out (chain[i+1])
    );
  end

  for (genvar k = 0; k <= TABLE_ENTRIES; k++) begin : g_live
    assign live_vec[k] = chain[k].live;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (chain[TABLE_ENTRIES].live) begin
      out_ch.valid <= 1'b1;
    end else if (out_fire) begin
      out_ch.valid <= 1'b0;
    end
    if (chain[TABLE_ENTRIES].live) begin
      out_ch.success    <= chain[TABLE_ENTRIES].ok;
      out_ch.next_alarm <= chain[TABLE_ENTRIES].alarm;
    end
  end

`ifndef NO_ASSERTIONS
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $countones(live_vec) <= 1)
    else $error("more than one request in the row");
  a_result_busy: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> busy)
    else $error("result shown with no request in flight");
  a_quiet_when_result: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> live_vec == '0)
    else $error("request still walking while result is held");
  a_enter_row: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> chain[0].live)
    else $error("accepted request did not enter the row");
`endif
endmodule

// ===== verif/tb_access_code_table_with_expiry_top.sv =====
// ----------------------------------------------------------------------------
// tb_access_code_table_with_expiry_top
// self-checking bench for the access code table with per-entry expiry
// ----------------------------------------------------------------------------
// Requests go in on in_ch and results come back on out_ch. A predictor in
// the bench keeps its own copy of the slots. Each result is checked in order
// against the prediction made when its request was accepted. The run starts
// with a short table of directed requests. Some rows carry a typed-in
// result. Random episodes follow: some fill the table, some mix all
// operations, some drain it, over a time base that also runs near the top
// of the minute range. Both channels stall in short random bursts. The
// result side holds off once for a long stretch, and the request side pauses
// until the block is drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_access_code_table_with_expiry_top;
  import acte_pkg::*;

  localparam logic [2:0] OP_BAD_LO  = 3'd5;
  localparam logic [2:0] OP_BAD_HI  = 3'd7;
  localparam logic [2:0] EXP_BAD_6  = 3'd6;
  localparam logic [2:0] EXP_BAD_7  = 3'd7;

  localparam int EP_FILL  = 0;
  localparam int EP_MIX   = 1;
  localparam int EP_DRAIN = 2;

  localparam int DIR_ROWS      = 25;
  localparam int RANDOM_ITEMS  = 1150;
  localparam int QUIET_ITEMS   = 150;
  localparam int HOLD_AT       = 400;
  localparam int DRAIN_AT      = 800;
  localparam int HOLD_CYCLES   = 300;
  localparam int TAIL_CYCLES   = 40;
  localparam int POOL_SIZE     = 32;

  typedef struct {
    logic [2:0]  op;
    logic [31:0] code;
    logic [2:0]  expiry;
    logic [31:0] now;
  } access_req_t;

  typedef struct {
    logic        ok;
    logic [31:0] alarm;
  } access_rsp_t;

  typedef struct {
    int          seq;
    logic [2:0]  op;
    logic        ok;
    logic [31:0] alarm;
  } owed_rsp_t;

  typedef struct {
    access_req_t req;
    bit          typed;
    logic        ok;
    logic [31:0] alarm;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  acte_in_if  in_ch ();
  acte_out_if out_ch ();

  access_code_table_with_expiry_top u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of the slots
  logic        slot_live  [TABLE_ENTRIES];
  logic        slot_aging [TABLE_ENTRIES];
  logic [31:0] slot_key   [TABLE_ENTRIES];
  logic [31:0] slot_due   [TABLE_ENTRIES];

  owed_rsp_t   owed_results [$];
  dir_row_t    dir_rows [DIR_ROWS];
  logic [31:0] code_pool [POOL_SIZE];
  int          pool_n = 0;
  int          pool_wr = 0;
  logic [31:0] cur_now = '0;

  bit          idle_on = 1'b1;
  bit          hold_req = 1'b0;
  int          stall_left = 0;

  int unsigned n_sent = 0;
  int unsigned n_checked = 0;
  int unsigned n_errors = 0;
  int unsigned n_mismatch = 0;
  int unsigned n_overwrite = 0;
  int unsigned n_aged = 0;
  int unsigned n_saturated = 0;
  int unsigned n_holds = 0;
  int unsigned n_op [8];

  function automatic logic [31:0] lifetime_of(input logic [2:0] choice);
    case (choice)
      EXP_MINUTE: return 32'd1;
      EXP_DAY:    return MIN_PER_DAY;
      EXP_3DAYS:  return 32'd3 * MIN_PER_DAY;
      EXP_WEEK:   return 32'd7 * MIN_PER_DAY;
      EXP_30DAYS: return 32'd30 * MIN_PER_DAY;
      default:    return 32'd0;
    endcase
  endfunction

  task automatic predict_access(input access_req_t r, output access_rsp_t p);
    logic [31:0] key;
    logic [31:0] life;
    logic [32:0] due;
    int          pick;
    key  = r.code & CODE_MASK;
    life = lifetime_of(r.expiry);
    p.ok = 1'b0;
    case (r.op)
      OP_MATCH: begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
          if (slot_live[i] && slot_key[i] == key) p.ok = 1'b1;
      end
      OP_ADD: begin
        pick = TABLE_ENTRIES - 1;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
          if (!slot_live[i]) begin
            pick = i;
            p.ok = 1'b1;
          end
        if (!p.ok) n_overwrite++;
        slot_key[pick]   = key;
        slot_live[pick]  = 1'b1;
        slot_aging[pick] = (life != 32'd0);
        if (life != 32'd0) begin
          due = {1'b0, r.now} + {1'b0, life};
          if (due > {1'b0, MAX_DEADLINE}) begin
            due = {1'b0, MAX_DEADLINE};
            n_saturated++;
          end
          slot_due[pick] = due[31:0];
        end
      end
      OP_INVAL: begin
        pick = -1;
        for (int i = 0; i < TABLE_ENTRIES; i++)
          if (pick < 0 && slot_live[i] && slot_key[i] == key) pick = i;
        if (pick >= 0) begin
          slot_live[pick] = 1'b0;
          p.ok = 1'b1;
        end
      end
      OP_EXPIRE: begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
          if (slot_live[i] && slot_aging[i] && slot_due[i] < r.now) begin
            slot_live[i] = 1'b0;
            n_aged++;
          end
        p.ok = 1'b1;
      end
      OP_CLEAR: begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          slot_live[i]  = 1'b0;
          slot_aging[i] = 1'b0;
          slot_key[i]   = '0;
          slot_due[i]   = '0;
        end
        p.ok = 1'b1;
      end
      default: ;
    endcase
    p.alarm = NO_ALARM;
    for (int i = 0; i < TABLE_ENTRIES; i++)
      if (slot_live[i] && slot_aging[i] && slot_due[i] < p.alarm) p.alarm = slot_due[i];
  endtask

  task automatic send_req(input access_req_t r, input bit typed, input logic t_ok,
                          input logic [31:0] t_alarm);
    int          gap;
    access_rsp_t p;
    owed_rsp_t   o;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 4);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.op            <= r.op;
    in_ch.code_value    <= r.code;
    in_ch.expiry_choice <= r.expiry;
    in_ch.now_minutes   <= r.now;
    do @(posedge clk); while (!in_ch.ready);
    predict_access(r, p);
    o.seq   = n_sent;
    o.op    = r.op;
    o.ok    = typed ? t_ok : p.ok;
    o.alarm = typed ? t_alarm : p.alarm;
    owed_results.push_back(o);
    n_op[r.op]++;
    n_sent++;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [2:0] pick_op(input int kind);
    int r;
    r = $urandom_range(0, 99);
    case (kind)
      EP_FILL: begin
        if (r < 60) return OP_ADD;
        if (r < 75) return OP_MATCH;
        if (r < 85) return OP_INVAL;
        if (r < 97) return OP_EXPIRE;
        if (r < 98) return OP_CLEAR;
      end
      EP_MIX: begin
        if (r < 25) return OP_ADD;
        if (r < 55) return OP_MATCH;
        if (r < 75) return OP_INVAL;
        if (r < 93) return OP_EXPIRE;
        if (r < 96) return OP_CLEAR;
      end
      default: begin
        if (r < 10) return OP_ADD;
        if (r < 30) return OP_MATCH;
        if (r < 65) return OP_INVAL;
        if (r < 95) return OP_EXPIRE;
        if (r < 98) return OP_CLEAR;
      end
    endcase
    return 3'($urandom_range(OP_BAD_LO, OP_BAD_HI));
  endfunction

  function automatic logic [31:0] pick_code();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 32'h0000_0000;
    if (r == 1) return 32'hFFFF_FFFF;
    if (pool_n > 0 && r < 15) return code_pool[$urandom_range(0, pool_n - 1)];
    return $urandom;
  endfunction

  task automatic advance_now(input logic [31:0] step);
    logic [32:0] s;
    s = {1'b0, cur_now} + {1'b0, step};
    cur_now = (s > {1'b0, MAX_DEADLINE}) ? MAX_DEADLINE : s[31:0];
  endtask

  task automatic gen_item(input int kind, output access_req_t r);
    if ($urandom_range(0, 7) == 0) advance_now($urandom_range(0, 60000));
    else advance_now($urandom_range(0, 1500));
    r.op     = pick_op(kind);
    r.code   = pick_code();
    r.expiry = 3'($urandom_range(0, 7));
    r.now    = cur_now;
    if ($urandom_range(0, 49) == 0) begin
      r.now = $urandom;
      if (r.now == NO_ALARM) r.now = MAX_DEADLINE;
    end
    if (r.op == OP_ADD) begin
      code_pool[pool_wr] = r.code;
      pool_wr = (pool_wr + 1) % POOL_SIZE;
      if (pool_n < POOL_SIZE) pool_n++;
    end
  endtask

  task automatic report_mismatch(input owed_rsp_t o, input string field,
                                 input logic [31:0] want, input logic [31:0] got);
    n_mismatch++;
    n_errors++;
    if (n_mismatch <= 10)
      $display("mismatch on request %0d (op %0d) %s: expected %08h, got %08h",
               o.seq, o.op, field, want, got);
  endtask

  task automatic check_result();
    owed_rsp_t o;
    if (owed_results.size() == 0) begin
      n_errors++;
      $display("result with no request outstanding: success %0b next_alarm %08h",
               out_ch.success, out_ch.next_alarm);
    end else begin
      o = owed_results.pop_front();
      if (out_ch.success !== o.ok)
        report_mismatch(o, "success", {31'd0, o.ok}, {31'd0, out_ch.success});
      if (out_ch.next_alarm !== o.alarm)
        report_mismatch(o, "next_alarm", o.alarm, out_ch.next_alarm);
      n_checked++;
    end
  endtask

  // result side: checks and random stalls
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid && out_ch.ready) check_result();
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = HOLD_CYCLES;
        n_holds++;
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 3);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    #3_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    access_req_t r;
    int          kind;
    int          ep_len;
    int          n_rand;
    int          base_pick;
    in_ch.valid         <= 1'b0;
    in_ch.op            <= OP_MATCH;
    in_ch.code_value    <= '0;
    in_ch.expiry_choice <= EXP_NEVER;
    in_ch.now_minutes   <= '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      slot_live[i]  = 1'b0;
      slot_aging[i] = 1'b0;
      slot_key[i]   = '0;
      slot_due[i]   = '0;
    end
    for (int i = 0; i < 8; i++) n_op[i] = 0;

    dir_rows = '{
      '{'{OP_MATCH,  32'h0000_0000, EXP_NEVER,  32'h0000_0000}, 1'b1, 1'b0, NO_ALARM},
      '{'{OP_INVAL,  32'hFFFF_FFFF, EXP_NEVER,  32'h0000_0000}, 1'b1, 1'b0, NO_ALARM},
      '{'{OP_EXPIRE, 32'h0000_0000, EXP_NEVER,  MAX_DEADLINE},  1'b1, 1'b1, NO_ALARM},
      '{'{OP_BAD_LO, 32'h0000_0000, EXP_NEVER,  32'h0000_0000}, 1'b1, 1'b0, NO_ALARM},
      '{'{OP_BAD_HI, 32'hFFFF_FFFF, EXP_BAD_7,  MAX_DEADLINE},  1'b1, 1'b0, NO_ALARM},
      '{'{OP_ADD,    32'hFFFF_FFFF, EXP_NEVER,  32'h0000_0000}, 1'b1, 1'b1, NO_ALARM},
      '{'{OP_ADD,    32'h0000_0000, EXP_MINUTE, 32'h0000_0000}, 1'b1, 1'b1, 32'd1},
      '{'{OP_ADD,    32'h1234_5678, EXP_30DAYS, MAX_DEADLINE},  1'b1, 1'b1, 32'd1},
      '{'{OP_ADD,    32'hA5A5_A5A5, EXP_BAD_6,  32'd100},       1'b1, 1'b1, 32'd1},
      '{'{OP_ADD,    32'h5A5A_5A5A, EXP_BAD_7,  32'd100},       1'b1, 1'b1, 32'd1},
      '{'{OP_ADD,    32'h0000_0001, EXP_DAY,    32'd1000},      1'b0, 1'b0, 32'd0},
      '{'{OP_ADD,    32'h8000_0000, EXP_3DAYS,  32'd0},         1'b0, 1'b0, 32'd0},
      '{'{OP_ADD,    32'h7FFF_FFFF, EXP_WEEK,   32'd50},        1'b0, 1'b0, 32'd0},
      '{'{OP_MATCH,  32'hFFFF_FFFF, EXP_NEVER,  32'd0},         1'b1, 1'b1, 32'd1},
      '{'{OP_MATCH,  32'h0000_0000, EXP_NEVER,  32'd0},         1'b1, 1'b1, 32'd1},
      '{'{OP_MATCH,  32'h1357_2468, EXP_NEVER,  32'd0},         1'b1, 1'b0, 32'd1},
      '{'{OP_EXPIRE, 32'h0000_0000, EXP_NEVER,  32'd1},         1'b1, 1'b1, 32'd1},
      '{'{OP_EXPIRE, 32'h0000_0000, EXP_NEVER,  32'd2},         1'b0, 1'b0, 32'd0},
      '{'{OP_INVAL,  32'h0000_0000, EXP_NEVER,  32'd0},         1'b0, 1'b0, 32'd0},
      '{'{OP_INVAL,  32'h0000_0001, EXP_NEVER,  32'd0},         1'b0, 1'b0, 32'd0},
      '{'{OP_INVAL,  32'h0000_0001, EXP_NEVER,  32'd0},         1'b0, 1'b0, 32'd0},
      '{'{OP_ADD,    32'h0000_0000, EXP_MINUTE, MAX_DEADLINE},  1'b0, 1'b0, 32'd0},
      '{'{OP_EXPIRE, 32'h0000_0000, EXP_NEVER,  MAX_DEADLINE},  1'b0, 1'b0, 32'd0},
      '{'{OP_CLEAR,  32'h0000_0000, EXP_NEVER,  32'd0},         1'b1, 1'b1, NO_ALARM},
      '{'{OP_MATCH,  32'hFFFF_FFFF, EXP_NEVER,  32'd0},         1'b1, 1'b0, NO_ALARM}
    };

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++)
      send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].ok, dir_rows[i].alarm);
    wait_drained();

    n_rand = 0;
    while (n_rand < RANDOM_ITEMS) begin
      kind   = $urandom_range(EP_FILL, EP_DRAIN);
      ep_len = $urandom_range(20, 60);
      idle_on = (n_rand < RANDOM_ITEMS - QUIET_ITEMS) && ($urandom_range(0, 3) != 0);
      base_pick = $urandom_range(0, 9);
      if (base_pick < 2) cur_now = MAX_DEADLINE - 32'($urandom_range(0, 100000));
      else if (base_pick == 2) cur_now = 32'($urandom_range(0, 50));
      else begin
        cur_now = $urandom;
        if (cur_now == NO_ALARM) cur_now = MAX_DEADLINE;
      end
      for (int k = 0; k < ep_len && n_rand < RANDOM_ITEMS; k++) begin
        if (n_rand == HOLD_AT) hold_req = 1'b1;
        if (n_rand == DRAIN_AT) wait_drained();
        if (n_rand >= RANDOM_ITEMS - QUIET_ITEMS) idle_on = 1'b0;
        gen_item(kind, r);
        send_req(r, 1'b0, 1'b0, 32'd0);
        n_rand++;
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d requests, %0d results checked: match %0d, add %0d, invalidate %0d,",
             n_sent, n_checked, n_op[OP_MATCH], n_op[OP_ADD], n_op[OP_INVAL]);
    $display("expire %0d, clear %0d, unused op %0d; %0d full-table adds, %0d aged out, %0d capped",
             n_op[OP_EXPIRE], n_op[OP_CLEAR], n_op[5] + n_op[6] + n_op[7], n_overwrite,
             n_aged, n_saturated);
    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== access_code_table_with_expiry_top.f =====
hdl/acte_pkg.sv
hdl/acte_in_if.sv
hdl/acte_out_if.sv
hdl/acte_cell.sv
hdl/access_code_table_with_expiry_top.sv
verif/tb_access_code_table_with_expiry_top.sv
